// File: sv/dah_pkg.sv
// types, codes and helpers for the dictionary and algorithm handshake
`default_nettype none

package dah_pkg;

  localparam int unsigned EpochW    = 64;
  localparam int unsigned HdrW      = 2;
  localparam int unsigned AlgoMaskW = 3;
  localparam int unsigned AlgoIdxW  = 2;

  localparam logic [AlgoMaskW-1:0] LocalAlgosReset = AlgoMaskW'(1);

  typedef enum logic [1:0] {
    ActAnnounce = 2'd0,
    ActSetAlgos = 2'd1,
    ActConsume  = 2'd2,
    ActProduce  = 2'd3
  } act_e;

  typedef enum logic [HdrW-1:0] {
    HdrNone   = 2'd0,
    HdrUpdate = 2'd1,
    HdrCommit = 2'd2
  } hdr_e;

  // pending flags of both directions
  typedef struct packed {
    logic send_update;
    logic send_commit;
    logic recv_update;
    logic recv_commit;
  } pend_t;

  // index of the highest set bit among the first count algorithms, raw if none
  function automatic logic [AlgoIdxW-1:0] algo_pick(logic [AlgoMaskW-1:0] set,
                                                    int unsigned count);
    logic [AlgoIdxW-1:0] idx;
    idx = '0;
    for (int unsigned i = 0; i < AlgoMaskW; i++) begin
      if (i < count && set[i]) begin
        idx = AlgoIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: sv/dah_if.sv
// item channel interfaces: incoming events and outgoing results
`default_nettype none

interface dah_in_if
  import dah_pkg::*;
#(
  parameter int unsigned DICT_HANDLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [DICT_HANDLE_BITS-1:0] dict_handle;
  logic [AlgoMaskW-1:0]        algo_mask;
  logic [HdrW-1:0]             rx_sender_header;
  logic [EpochW-1:0]           rx_sender_epoch;
  logic [DICT_HANDLE_BITS-1:0] rx_sender_dict;
  logic [HdrW-1:0]             rx_receiver_header;
  logic [EpochW-1:0]           rx_receiver_epoch;
  logic [DICT_HANDLE_BITS-1:0] rx_receiver_dict;
  logic [AlgoMaskW-1:0]        rx_receiver_algos;

  modport source (
    output valid, action, dict_handle, algo_mask, rx_sender_header, rx_sender_epoch,
           rx_sender_dict, rx_receiver_header, rx_receiver_epoch, rx_receiver_dict,
           rx_receiver_algos,
    input  ready
  );

  modport sink (
    input  valid, action, dict_handle, algo_mask, rx_sender_header, rx_sender_epoch,
           rx_sender_dict, rx_receiver_header, rx_receiver_epoch, rx_receiver_dict,
           rx_receiver_algos,
    output ready
  );
endinterface

interface dah_out_if
  import dah_pkg::*;
#(
  parameter int unsigned DICT_HANDLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        frame_valid;
  logic [HdrW-1:0]             tx_sender_header;
  logic [EpochW-1:0]           tx_sender_epoch;
  logic [DICT_HANDLE_BITS-1:0] tx_sender_dict;
  logic [HdrW-1:0]             tx_receiver_header;
  logic [EpochW-1:0]           tx_receiver_epoch;
  logic [DICT_HANDLE_BITS-1:0] tx_receiver_dict;
  logic [AlgoMaskW-1:0]        tx_receiver_algos;
  logic [AlgoIdxW-1:0]         current_sender_algo;
  logic [DICT_HANDLE_BITS-1:0] current_sender_dict;
  logic [DICT_HANDLE_BITS-1:0] current_receiver_dict;
  logic                        needs_progress;

  modport source (
    output valid, frame_valid, tx_sender_header, tx_sender_epoch, tx_sender_dict,
           tx_receiver_header, tx_receiver_epoch, tx_receiver_dict, tx_receiver_algos,
           current_sender_algo, current_sender_dict, current_receiver_dict,
           needs_progress,
    input  ready
  );

  modport sink (
    input  valid, frame_valid, tx_sender_header, tx_sender_epoch, tx_sender_dict,
           tx_receiver_header, tx_receiver_epoch, tx_receiver_dict, tx_receiver_algos,
           current_sender_algo, current_sender_dict, current_receiver_dict,
           needs_progress,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/dict_algo_handshake_unit.sv
// top level of the dictionary and algorithm handshake: event register, step logic, result register
// path: event register, step logic, result register; a held result stalls the step
// throughput: one event per cycle while the sink is ready; state updates in the step logic
// a result held by a stalled sink lets one more event wait in the event register
// reset: asynchronous, clears valid flags, epochs, pending flags and handles; local set is raw only
`default_nettype none

module dict_algo_handshake_unit
  import dah_pkg::*;
#(
  parameter int unsigned DICT_HANDLE_BITS = 16,
  parameter int unsigned ALGO_COUNT       = 3
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dah_in_if.sink     in_i,
  dah_out_if.source  out_o
);

  // ---------------------------------------------------------------------------
  // event register
  // ---------------------------------------------------------------------------
  logic                        ev_valid_q;
  logic [1:0]                  ev_action_q;
  logic [DICT_HANDLE_BITS-1:0] ev_dict_q;
  logic [AlgoMaskW-1:0]        ev_algo_mask_q;
  logic [HdrW-1:0]             ev_s_hdr_q;
  logic [EpochW-1:0]           ev_s_epoch_q;
  logic [DICT_HANDLE_BITS-1:0] ev_s_dict_q;
  logic [HdrW-1:0]             ev_r_hdr_q;
  logic [EpochW-1:0]           ev_r_epoch_q;
  logic [DICT_HANDLE_BITS-1:0] ev_r_dict_q;
  logic [AlgoMaskW-1:0]        ev_r_algos_q;

  logic in_fire;
  logic step_fire;   // registered event is applied to state and result this cycle
  logic res_valid_q;

  // the event moves on whenever the result register is free or being emptied
  assign step_fire  = ev_valid_q & (~res_valid_q | out_o.ready);
  assign in_i.ready = ~ev_valid_q | step_fire;
  assign in_fire    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      ev_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_action_q    <= in_i.action;
      ev_dict_q      <= in_i.dict_handle;
      ev_algo_mask_q <= in_i.algo_mask;
      ev_s_hdr_q     <= in_i.rx_sender_header;
      ev_s_epoch_q   <= in_i.rx_sender_epoch;
      ev_s_dict_q    <= in_i.rx_sender_dict;
      ev_r_hdr_q     <= in_i.rx_receiver_header;
      ev_r_epoch_q   <= in_i.rx_receiver_epoch;
      ev_r_dict_q    <= in_i.rx_receiver_dict;
      ev_r_algos_q   <= in_i.rx_receiver_algos;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake state
  // ---------------------------------------------------------------------------
  logic [EpochW-1:0]           send_epoch_q, send_epoch_d;
  logic [EpochW-1:0]           recv_epoch_q, recv_epoch_d;
  pend_t                       pend_q, pend_d;
  logic [DICT_HANDLE_BITS-1:0] send_recent_q, send_recent_d;
  logic [DICT_HANDLE_BITS-1:0] send_cmt_q, send_cmt_d;
  logic [DICT_HANDLE_BITS-1:0] send_cur_q, send_cur_d;
  logic [DICT_HANDLE_BITS-1:0] recv_recent_q, recv_recent_d;
  logic [DICT_HANDLE_BITS-1:0] recv_cmt_q, recv_cmt_d;
  logic [DICT_HANDLE_BITS-1:0] recv_cur_q, recv_cur_d;
  logic [AlgoIdxW-1:0]         send_cur_algo_q, send_cur_algo_d;
  logic [AlgoIdxW-1:0]         send_cmt_algo_q, send_cmt_algo_d;
  logic [AlgoMaskW-1:0]        local_algos_q, local_algos_d;

  // step results, straight from the logic
  logic                        st_frame_valid;
  logic [HdrW-1:0]             st_s_hdr;
  logic [EpochW-1:0]           st_s_epoch;
  logic [DICT_HANDLE_BITS-1:0] st_s_dict;
  logic [HdrW-1:0]             st_r_hdr;
  logic [EpochW-1:0]           st_r_epoch;
  logic [DICT_HANDLE_BITS-1:0] st_r_dict;
  logic [AlgoMaskW-1:0]        st_r_algos;
  logic                        st_progress;

  dah_step #(
    .DICT_HANDLE_BITS (DICT_HANDLE_BITS),
    .ALGO_COUNT       (ALGO_COUNT)
  ) u_step (
    .action_i             (ev_action_q),
    .dict_handle_i        (ev_dict_q),
    .algo_mask_i          (ev_algo_mask_q),
    .rx_sender_header_i   (ev_s_hdr_q),
    .rx_sender_epoch_i    (ev_s_epoch_q),
    .rx_sender_dict_i     (ev_s_dict_q),
    .rx_receiver_header_i (ev_r_hdr_q),
    .rx_receiver_epoch_i  (ev_r_epoch_q),
    .rx_receiver_dict_i   (ev_r_dict_q),
    .rx_receiver_algos_i  (ev_r_algos_q),
    .send_epoch_i         (send_epoch_q),
    .recv_epoch_i         (recv_epoch_q),
    .pend_i               (pend_q),
    .send_recent_i        (send_recent_q),
    .send_committed_i     (send_cmt_q),
    .send_current_i       (send_cur_q),
    .recv_recent_i        (recv_recent_q),
    .recv_committed_i     (recv_cmt_q),
    .recv_current_i       (recv_cur_q),
    .send_cur_algo_i      (send_cur_algo_q),
    .send_cmt_algo_i      (send_cmt_algo_q),
    .local_algos_i        (local_algos_q),
    .send_epoch_o         (send_epoch_d),
    .recv_epoch_o         (recv_epoch_d),
    .pend_o               (pend_d),
    .send_recent_o        (send_recent_d),
    .send_committed_o     (send_cmt_d),
    .send_current_o       (send_cur_d),
    .recv_recent_o        (recv_recent_d),
    .recv_committed_o     (recv_cmt_d),
    .recv_current_o       (recv_cur_d),
    .send_cur_algo_o      (send_cur_algo_d),
    .send_cmt_algo_o      (send_cmt_algo_d),
    .local_algos_o        (local_algos_d),
    .frame_valid_o        (st_frame_valid),
    .tx_sender_header_o   (st_s_hdr),
    .tx_sender_epoch_o    (st_s_epoch),
    .tx_sender_dict_o     (st_s_dict),
    .tx_receiver_header_o (st_r_hdr),
    .tx_receiver_epoch_o  (st_r_epoch),
    .tx_receiver_dict_o   (st_r_dict),
    .tx_receiver_algos_o  (st_r_algos),
    .needs_progress_o     (st_progress)
  );

  // state moves only when an event is applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_epoch_q    <= '0;
      recv_epoch_q    <= '0;
      pend_q          <= '0;
      send_recent_q   <= '0;
      send_cmt_q      <= '0;
      send_cur_q      <= '0;
      recv_recent_q   <= '0;
      recv_cmt_q      <= '0;
      recv_cur_q      <= '0;
      send_cur_algo_q <= '0;
      send_cmt_algo_q <= '0;
      local_algos_q   <= LocalAlgosReset;
    end else if (step_fire) begin
      send_epoch_q    <= send_epoch_d;
      recv_epoch_q    <= recv_epoch_d;
      pend_q          <= pend_d;
      send_recent_q   <= send_recent_d;
      send_cmt_q      <= send_cmt_d;
      send_cur_q      <= send_cur_d;
      recv_recent_q   <= recv_recent_d;
      recv_cmt_q      <= recv_cmt_d;
      recv_cur_q      <= recv_cur_d;
      send_cur_algo_q <= send_cur_algo_d;
      send_cmt_algo_q <= send_cmt_algo_d;
      local_algos_q   <= local_algos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                        res_valid_d;
  logic                        res_frame_q;
  logic [HdrW-1:0]             res_s_hdr_q;
  logic [EpochW-1:0]           res_s_epoch_q;
  logic [DICT_HANDLE_BITS-1:0] res_s_dict_q;
  logic [HdrW-1:0]             res_r_hdr_q;
  logic [EpochW-1:0]           res_r_epoch_q;
  logic [DICT_HANDLE_BITS-1:0] res_r_dict_q;
  logic [AlgoMaskW-1:0]        res_r_algos_q;
  logic [AlgoIdxW-1:0]         res_cur_algo_q;
  logic [DICT_HANDLE_BITS-1:0] res_cur_send_q;
  logic [DICT_HANDLE_BITS-1:0] res_cur_recv_q;
  logic                        res_progress_q;

  always_comb begin
    if (step_fire) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // current handles and algorithm are the values after the step
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_frame_q    <= st_frame_valid;
      res_s_hdr_q    <= st_s_hdr;
      res_s_epoch_q  <= st_s_epoch;
      res_s_dict_q   <= st_s_dict;
      res_r_hdr_q    <= st_r_hdr;
      res_r_epoch_q  <= st_r_epoch;
      res_r_dict_q   <= st_r_dict;
      res_r_algos_q  <= st_r_algos;
      res_cur_algo_q <= send_cur_algo_d;
      res_cur_send_q <= send_cur_d;
      res_cur_recv_q <= recv_cur_d;
      res_progress_q <= st_progress;
    end
  end

  assign out_o.valid                 = res_valid_q;
  assign out_o.frame_valid           = res_frame_q;
  assign out_o.tx_sender_header      = res_s_hdr_q;
  assign out_o.tx_sender_epoch       = res_s_epoch_q;
  assign out_o.tx_sender_dict        = res_s_dict_q;
  assign out_o.tx_receiver_header    = res_r_hdr_q;
  assign out_o.tx_receiver_epoch     = res_r_epoch_q;
  assign out_o.tx_receiver_dict      = res_r_dict_q;
  assign out_o.tx_receiver_algos     = res_r_algos_q;
  assign out_o.current_sender_algo   = res_cur_algo_q;
  assign out_o.current_sender_dict   = res_cur_send_q;
  assign out_o.current_receiver_dict = res_cur_recv_q;
  assign out_o.needs_progress        = res_progress_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // no state change without an applied event
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> ($stable(send_epoch_q) && $stable(recv_epoch_q) && $stable(pend_q)))
    else $error("handshake state changed without an event");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> in_i.ready)
    else $error("input stalled while result register is empty");

  // produce with nothing pending yields no frame
  a_idle_produce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && ev_action_q == ActProduce && pend_q == '0) |=> !res_frame_q)
    else $error("frame produced with nothing pending");

  // a frame and a progress request never come from the same event
  a_frame_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_progress_q) |-> !res_frame_q)
    else $error("progress requested by a produce event");

endmodule

`default_nettype wire

// File: sv/dah_step.sv
// next-state and result logic for one handshake event
`default_nettype none

module dah_step
  import dah_pkg::*;
#(
  parameter int unsigned DICT_HANDLE_BITS = 16,
  parameter int unsigned ALGO_COUNT       = 3
) (
  // registered event
  input  wire logic [1:0]                  action_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] dict_handle_i,
  input  wire logic [AlgoMaskW-1:0]        algo_mask_i,
  input  wire logic [HdrW-1:0]             rx_sender_header_i,
  input  wire logic [EpochW-1:0]           rx_sender_epoch_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] rx_sender_dict_i,
  input  wire logic [HdrW-1:0]             rx_receiver_header_i,
  input  wire logic [EpochW-1:0]           rx_receiver_epoch_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] rx_receiver_dict_i,
  input  wire logic [AlgoMaskW-1:0]        rx_receiver_algos_i,
  // present state
  input  wire logic [EpochW-1:0]           send_epoch_i,
  input  wire logic [EpochW-1:0]           recv_epoch_i,
  input  wire pend_t                       pend_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] send_recent_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] send_committed_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] send_current_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] recv_recent_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] recv_committed_i,
  input  wire logic [DICT_HANDLE_BITS-1:0] recv_current_i,
  input  wire logic [AlgoIdxW-1:0]         send_cur_algo_i,
  input  wire logic [AlgoIdxW-1:0]         send_cmt_algo_i,
  input  wire logic [AlgoMaskW-1:0]        local_algos_i,
  // next state
  output logic [EpochW-1:0]                send_epoch_o,
  output logic [EpochW-1:0]                recv_epoch_o,
  output pend_t                            pend_o,
  output logic [DICT_HANDLE_BITS-1:0]      send_recent_o,
  output logic [DICT_HANDLE_BITS-1:0]      send_committed_o,
  output logic [DICT_HANDLE_BITS-1:0]      send_current_o,
  output logic [DICT_HANDLE_BITS-1:0]      recv_recent_o,
  output logic [DICT_HANDLE_BITS-1:0]      recv_committed_o,
  output logic [DICT_HANDLE_BITS-1:0]      recv_current_o,
  output logic [AlgoIdxW-1:0]              send_cur_algo_o,
  output logic [AlgoIdxW-1:0]              send_cmt_algo_o,
  output logic [AlgoMaskW-1:0]             local_algos_o,
  // result item
  output logic                             frame_valid_o,
  output logic [HdrW-1:0]                  tx_sender_header_o,
  output logic [EpochW-1:0]                tx_sender_epoch_o,
  output logic [DICT_HANDLE_BITS-1:0]      tx_sender_dict_o,
  output logic [HdrW-1:0]                  tx_receiver_header_o,
  output logic [EpochW-1:0]                tx_receiver_epoch_o,
  output logic [DICT_HANDLE_BITS-1:0]      tx_receiver_dict_o,
  output logic [AlgoMaskW-1:0]             tx_receiver_algos_o,
  output logic                             needs_progress_o
);

  logic [EpochW-1:0] send_epoch_inc;

  assign send_epoch_inc = send_epoch_i + EpochW'(1);

  always_comb begin
    send_epoch_o         = send_epoch_i;
    recv_epoch_o         = recv_epoch_i;
    pend_o               = pend_i;
    send_recent_o        = send_recent_i;
    send_committed_o     = send_committed_i;
    send_current_o       = send_current_i;
    recv_recent_o        = recv_recent_i;
    recv_committed_o     = recv_committed_i;
    recv_current_o       = recv_current_i;
    send_cur_algo_o      = send_cur_algo_i;
    send_cmt_algo_o      = send_cmt_algo_i;
    local_algos_o        = local_algos_i;
    frame_valid_o        = 1'b0;
    tx_sender_header_o   = HdrNone;
    tx_sender_epoch_o    = '0;
    tx_sender_dict_o     = '0;
    tx_receiver_header_o = HdrNone;
    tx_receiver_epoch_o  = '0;
    tx_receiver_dict_o   = '0;
    tx_receiver_algos_o  = '0;
    needs_progress_o     = 1'b0;

    case (act_e'(action_i))
      ActAnnounce: begin
        send_recent_o      = dict_handle_i;
        send_epoch_o       = send_epoch_inc;
        pend_o.send_update = 1'b1;
        pend_o.send_commit = 1'b0;
        recv_recent_o      = dict_handle_i;
        pend_o.recv_update = 1'b1;
        pend_o.recv_commit = 1'b0;
        needs_progress_o   = 1'b1;
      end
      ActSetAlgos: begin
        local_algos_o      = algo_mask_i;
        send_epoch_o       = send_epoch_inc;
        pend_o.send_update = 1'b1;
        pend_o.send_commit = 1'b0;
        pend_o.recv_update = 1'b1;
        needs_progress_o   = 1'b1;
      end
      ActConsume: begin
        // receiver half of the frame acts on our send direction
        if (rx_receiver_header_i == HdrUpdate) begin
          send_epoch_o       = send_epoch_inc;
          pend_o.send_update = 1'b1;
          pend_o.send_commit = 1'b0;
          needs_progress_o   = 1'b1;
        end else if (rx_receiver_header_i == HdrCommit &&
                     rx_receiver_epoch_i == send_epoch_i) begin
          pend_o.send_commit = 1'b1;
          if (send_committed_i != rx_receiver_dict_i) begin
            send_committed_o = send_current_i;
          end
          send_cmt_algo_o  = algo_pick(rx_receiver_algos_i & local_algos_i, ALGO_COUNT);
          needs_progress_o = 1'b1;
        end
        // sender half acts on our receive direction
        if (rx_sender_header_i == HdrUpdate) begin
          pend_o.recv_commit = 1'b1;
          pend_o.recv_update = 1'b0;
          if (rx_sender_dict_i == recv_recent_i) begin
            recv_committed_o = recv_recent_i;
          end
          recv_epoch_o     = rx_sender_epoch_i;
          needs_progress_o = 1'b1;
        end else if (rx_sender_header_i == HdrCommit) begin
          if (rx_sender_dict_i == recv_committed_i) begin
            recv_current_o = recv_committed_i;
          end
        end
      end
      ActProduce: begin
        frame_valid_o = pend_i.send_update | pend_i.send_commit |
                        pend_i.recv_update | pend_i.recv_commit;
        // a pending commit goes first, an update waits for the next frame
        if (pend_i.send_commit) begin
          pend_o.send_commit = 1'b0;
          send_current_o     = send_committed_i;
          send_cur_algo_o    = send_cmt_algo_i;
          tx_sender_header_o = HdrCommit;
          tx_sender_epoch_o  = send_epoch_i;
          tx_sender_dict_o   = send_committed_i;
        end else if (pend_i.send_update) begin
          pend_o.send_update = 1'b0;
          send_committed_o   = send_recent_i;
          tx_sender_header_o = HdrUpdate;
          tx_sender_epoch_o  = send_epoch_i;
          tx_sender_dict_o   = send_recent_i;
        end
        if (pend_i.recv_commit) begin
          pend_o.recv_commit   = 1'b0;
          tx_receiver_header_o = HdrCommit;
          tx_receiver_epoch_o  = recv_epoch_i;
          tx_receiver_dict_o   = recv_committed_i;
          tx_receiver_algos_o  = local_algos_i;
        end else if (pend_i.recv_update) begin
          pend_o.recv_update   = 1'b0;
          tx_receiver_header_o = HdrUpdate;
          tx_receiver_epoch_o  = recv_epoch_i;
          tx_receiver_dict_o   = recv_recent_i;
          tx_receiver_algos_o  = local_algos_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/dah_checker.sv
// predicts each step of the dictionary and algorithm handshake and checks every result item
`default_nettype none

module dah_checker
  import dah_pkg::*;
#(
  parameter int unsigned DICT_HANDLE_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dah_in_if           in_mon_i,
  dah_out_if          out_mon_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned frames_o
);

  typedef logic [DICT_HANDLE_BITS-1:0] handle_t;

  typedef struct packed {
    act_e                 action;
    handle_t              dict;
    logic [AlgoMaskW-1:0] algos;
    logic [HdrW-1:0]      s_hdr;
    logic [EpochW-1:0]    s_epoch;
    handle_t              s_dict;
    logic [HdrW-1:0]      r_hdr;
    logic [EpochW-1:0]    r_epoch;
    handle_t              r_dict;
    logic [AlgoMaskW-1:0] r_algos;
  } link_event_t;

  typedef struct packed {
    logic                 frame_valid;
    logic [HdrW-1:0]      s_hdr;
    logic [EpochW-1:0]    s_epoch;
    handle_t              s_dict;
    logic [HdrW-1:0]      r_hdr;
    logic [EpochW-1:0]    r_epoch;
    handle_t              r_dict;
    logic [AlgoMaskW-1:0] r_algos;
    logic [AlgoIdxW-1:0]  cur_algo;
    handle_t              cur_s_dict;
    handle_t              cur_r_dict;
    logic                 progress;
  } step_outcome_t;

  // shadow of the handshake state
  logic [EpochW-1:0]    send_ep;
  logic [EpochW-1:0]    recv_ep;
  pend_t                pend;
  handle_t              snd_recent;
  handle_t              snd_committed;
  handle_t              snd_current;
  handle_t              rcv_recent;
  handle_t              rcv_committed;
  handle_t              rcv_current;
  logic [AlgoIdxW-1:0]  snd_cur_algo;
  logic [AlgoIdxW-1:0]  snd_cmt_algo;
  logic [AlgoMaskW-1:0] local_set;

  step_outcome_t outcome_q[$];
  int unsigned   mismatches = 0;
  int unsigned   frames     = 0;
  int unsigned   waiting    = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = waiting;
  assign frames_o      = frames;

  // best algorithm both sides support, raw when they share none
  function automatic logic [AlgoIdxW-1:0] best_shared(logic [AlgoMaskW-1:0] set);
    if (set[2]) begin
      return AlgoIdxW'(2);
    end
    if (set[1]) begin
      return AlgoIdxW'(1);
    end
    return '0;
  endfunction

  task automatic advance_handshake(input link_event_t e, output step_outcome_t r);
    logic prog;
    prog = 1'b0;
    r    = '0;
    case (e.action)
      ActAnnounce: begin
        snd_recent       = e.dict;
        send_ep          = send_ep + 1;
        pend.send_update = 1'b1;
        pend.send_commit = 1'b0;
        rcv_recent       = e.dict;
        pend.recv_update = 1'b1;
        pend.recv_commit = 1'b0;
        prog             = 1'b1;
      end
      ActSetAlgos: begin
        local_set        = e.algos;
        send_ep          = send_ep + 1;
        pend.send_update = 1'b1;
        pend.send_commit = 1'b0;
        pend.recv_update = 1'b1;
        prog             = 1'b1;
      end
      ActConsume: begin
        if (e.r_hdr == HdrUpdate) begin
          send_ep          = send_ep + 1;
          pend.send_update = 1'b1;
          pend.send_commit = 1'b0;
          prog             = 1'b1;
        end else if (e.r_hdr == HdrCommit && e.r_epoch == send_ep) begin
          pend.send_commit = 1'b1;
          if (snd_committed != e.r_dict) begin
            snd_committed = snd_current;
          end
          snd_cmt_algo = best_shared(e.r_algos & local_set);
          prog         = 1'b1;
        end
        if (e.s_hdr == HdrUpdate) begin
          pend.recv_commit = 1'b1;
          pend.recv_update = 1'b0;
          if (e.s_dict == rcv_recent) begin
            rcv_committed = rcv_recent;
          end
          recv_ep = e.s_epoch;
          prog    = 1'b1;
        end else if (e.s_hdr == HdrCommit) begin
          if (e.s_dict == rcv_committed) begin
            rcv_current = rcv_committed;
          end
        end
      end
      ActProduce: begin
        if (pend != '0) begin
          r.frame_valid = 1'b1;
          if (pend.send_commit) begin
            pend.send_commit = 1'b0;
            snd_current      = snd_committed;
            snd_cur_algo     = snd_cmt_algo;
            r.s_hdr          = HdrCommit;
            r.s_epoch        = send_ep;
            r.s_dict         = snd_current;
          end else if (pend.send_update) begin
            pend.send_update = 1'b0;
            snd_committed    = snd_recent;
            r.s_hdr          = HdrUpdate;
            r.s_epoch        = send_ep;
            r.s_dict         = snd_recent;
          end
          if (pend.recv_commit) begin
            pend.recv_commit = 1'b0;
            r.r_hdr          = HdrCommit;
            r.r_epoch        = recv_ep;
            r.r_dict         = rcv_committed;
            r.r_algos        = local_set;
          end else if (pend.recv_update) begin
            pend.recv_update = 1'b0;
            r.r_hdr          = HdrUpdate;
            r.r_epoch        = recv_ep;
            r.r_dict         = rcv_recent;
            r.r_algos        = local_set;
          end
        end
      end
      default: begin
      end
    endcase
    r.cur_algo   = snd_cur_algo;
    r.cur_s_dict = snd_current;
    r.cur_r_dict = rcv_current;
    r.progress   = prog;
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    step_outcome_t want;
    link_event_t   ev;
    if (!rst_ni) begin
      send_ep       = '0;
      recv_ep       = '0;
      pend          = '0;
      snd_recent    = '0;
      snd_committed = '0;
      snd_current   = '0;
      rcv_recent    = '0;
      rcv_committed = '0;
      rcv_current   = '0;
      snd_cur_algo  = '0;
      snd_cmt_algo  = '0;
      local_set     = LocalAlgosReset;
      outcome_q.delete();
      waiting = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result item with no event waiting for it");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (want.frame_valid) begin
            frames++;
          end
          check_field("frame_valid", want.frame_valid, out_mon_i.frame_valid);
          check_field("tx_sender_header", want.s_hdr, out_mon_i.tx_sender_header);
          check_field("tx_sender_epoch", want.s_epoch, out_mon_i.tx_sender_epoch);
          check_field("tx_sender_dict", want.s_dict, out_mon_i.tx_sender_dict);
          check_field("tx_receiver_header", want.r_hdr, out_mon_i.tx_receiver_header);
          check_field("tx_receiver_epoch", want.r_epoch, out_mon_i.tx_receiver_epoch);
          check_field("tx_receiver_dict", want.r_dict, out_mon_i.tx_receiver_dict);
          check_field("tx_receiver_algos", want.r_algos, out_mon_i.tx_receiver_algos);
          check_field("current_sender_algo", want.cur_algo, out_mon_i.current_sender_algo);
          check_field("current_sender_dict", want.cur_s_dict,
                      out_mon_i.current_sender_dict);
          check_field("current_receiver_dict", want.cur_r_dict,
                      out_mon_i.current_receiver_dict);
          check_field("needs_progress", want.progress, out_mon_i.needs_progress);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        ev.action  = act_e'(in_mon_i.action);
        ev.dict    = in_mon_i.dict_handle;
        ev.algos   = in_mon_i.algo_mask;
        ev.s_hdr   = in_mon_i.rx_sender_header;
        ev.s_epoch = in_mon_i.rx_sender_epoch;
        ev.s_dict  = in_mon_i.rx_sender_dict;
        ev.r_hdr   = in_mon_i.rx_receiver_header;
        ev.r_epoch = in_mon_i.rx_receiver_epoch;
        ev.r_dict  = in_mon_i.rx_receiver_dict;
        ev.r_algos = in_mon_i.rx_receiver_algos;
        advance_handshake(ev, want);
        outcome_q.insert(outcome_q.size(), want);
      end
      waiting = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// testbench top: drives link events into the handshake unit and gives the verdict
`default_nettype none

module tb_top;
  import dah_pkg::*;

  localparam int unsigned HandleW      = 16;
  localparam int unsigned AlgoCount    = 3;
  // header code the protocol never sends, must read as none
  localparam logic [HdrW-1:0] HdrBogus = 2'd3;
  // random items per idle mix, four mixes in all
  localparam int unsigned RandomPerMix = 432;
  // sink hold-off, long enough to fill event and result registers
  localparam int unsigned HoldCycles   = 300;
  // cycles with no item moving on either side before we give up
  localparam int unsigned QuietLimit   = 4000;
  // tail after the last result
  localparam int unsigned DrainCycles  = 8;

  typedef logic [HandleW-1:0] handle_t;

  typedef struct packed {
    act_e                 action;
    handle_t              dict;
    logic [AlgoMaskW-1:0] algos;
    logic [HdrW-1:0]      s_hdr;
    logic [EpochW-1:0]    s_epoch;
    handle_t              s_dict;
    logic [HdrW-1:0]      r_hdr;
    logic [EpochW-1:0]    r_epoch;
    handle_t              r_dict;
    logic [AlgoMaskW-1:0] r_algos;
  } link_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  dah_in_if  #(.DICT_HANDLE_BITS(HandleW)) in_ch ();
  dah_out_if #(.DICT_HANDLE_BITS(HandleW)) out_ch ();

  dict_algo_handshake_unit #(
    .DICT_HANDLE_BITS(HandleW),
    .ALGO_COUNT      (AlgoCount)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned frames;

  dah_checker #(
    .DICT_HANDLE_BITS(HandleW)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .frames_o     (frames)
  );

  // idle mix, changed between phases by the stimulus process
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // long sink hold-off, requested by the stimulus, counted by the sink process
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;

  // what the stimulus knows of the block, just enough to form matching replies:
  // the send epoch it has caused and the handle it announced last
  logic [EpochW-1:0] local_epoch = '0;
  handle_t           last_dict   = '0;

  int unsigned sent = 0;
  int unsigned act_seen[4];
  int unsigned quiet = 0;

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // 64-bit epoch with the extremes showing up now and then
  function automatic logic [EpochW-1:0] rand_epoch();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // handle: mostly a small pool so that matches happen, plus none and the extremes
  function automatic handle_t fresh_handle();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return handle_t'($urandom_range(7, 1));
      default: return handle_t'($urandom);
    endcase
  endfunction

  // one item on the input channel: optional sender gap, then hold until taken
  task automatic offer_event(link_event_t e);
    @(negedge clk_i);
    while (chance(gap_pct)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid              <= 1'b1;
    in_ch.action             <= e.action;
    in_ch.dict_handle        <= e.dict;
    in_ch.algo_mask          <= e.algos;
    in_ch.rx_sender_header   <= e.s_hdr;
    in_ch.rx_sender_epoch    <= e.s_epoch;
    in_ch.rx_sender_dict     <= e.s_dict;
    in_ch.rx_receiver_header <= e.r_hdr;
    in_ch.rx_receiver_epoch  <= e.r_epoch;
    in_ch.rx_receiver_dict   <= e.r_dict;
    in_ch.rx_receiver_algos  <= e.r_algos;
    do @(posedge clk_i); while (!in_ch.ready);
    // keep track of what the block will see, in item order
    sent++;
    act_seen[int'(e.action)]++;
    if (e.action == ActAnnounce || e.action == ActSetAlgos ||
        (e.action == ActConsume && e.r_hdr == HdrUpdate)) begin
      local_epoch = local_epoch + 1;
    end
    if (e.action == ActAnnounce) begin
      last_dict = e.dict;
    end
  endtask

  task automatic announce(handle_t h);
    link_event_t e;
    e        = '0;
    e.action = ActAnnounce;
    e.dict   = h;
    offer_event(e);
  endtask

  task automatic set_algos(logic [AlgoMaskW-1:0] m);
    link_event_t e;
    e        = '0;
    e.action = ActSetAlgos;
    e.algos  = m;
    offer_event(e);
  endtask

  task automatic produce();
    link_event_t e;
    e        = '0;
    e.action = ActProduce;
    offer_event(e);
  endtask

  // partner frame: receiver half (our send direction) first, then sender half
  task automatic consume(logic [HdrW-1:0] rh, logic [EpochW-1:0] re, handle_t rd,
                         logic [AlgoMaskW-1:0] ra, logic [HdrW-1:0] sh,
                         logic [EpochW-1:0] se, handle_t sd);
    link_event_t e;
    e         = '0;
    e.action  = ActConsume;
    e.r_hdr   = rh;
    e.r_epoch = re;
    e.r_dict  = rd;
    e.r_algos = ra;
    e.s_hdr   = sh;
    e.s_epoch = se;
    e.s_dict  = sd;
    offer_event(e);
  endtask

  // one well-formed round: local change, our update goes out, partner commits
  // and sends its own update, we commit back, partner commits, we switch over
  task automatic run_exchange();
    if (chance(60)) begin
      announce(fresh_handle());
    end else begin
      set_algos(AlgoMaskW'($urandom_range(7)));
    end
    produce();
    consume(chance(85) ? HdrCommit : HdrUpdate,
            chance(90) ? local_epoch : rand_epoch(),
            chance(80) ? last_dict : fresh_handle(),
            AlgoMaskW'($urandom_range(7)),
            HdrUpdate, rand_epoch(),
            chance(85) ? last_dict : fresh_handle());
    produce();
    consume(chance(70) ? HdrNone : HdrCommit, local_epoch, last_dict,
            AlgoMaskW'($urandom_range(7)),
            HdrCommit, rand_epoch(),
            chance(85) ? last_dict : fresh_handle());
    produce();
  endtask

  // sink side: random stalls, or the long hold-off when asked for
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !chance(stall_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    link_event_t noise;
    int unsigned base;
    int unsigned mix;
    foreach (act_seen[i]) begin
      act_seen[i] = 0;
    end
    in_ch.valid              = 1'b0;
    in_ch.action             = '0;
    in_ch.dict_handle        = '0;
    in_ch.algo_mask          = '0;
    in_ch.rx_sender_header   = '0;
    in_ch.rx_sender_epoch    = '0;
    in_ch.rx_sender_dict     = '0;
    in_ch.rx_receiver_header = '0;
    in_ch.rx_receiver_epoch  = '0;
    in_ch.rx_receiver_dict   = '0;
    in_ch.rx_receiver_algos  = '0;
    rst_ni                   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, no idling
    // nothing pending yet: produce gives no frame
    produce();
    // header code three on both halves reads as none, fields at their maximum
    consume(HdrBogus, '1, '1, 3'b111, HdrBogus, '1, '1);
    announce('1);
    set_algos(3'b110);
    produce();
    // partner update on both halves, receive epoch at its maximum
    consume(HdrUpdate, '0, '0, '0, HdrUpdate, '1, '1);
    // commit arrives while our own update is still pending
    consume(HdrCommit, local_epoch, '1, 3'b100, HdrNone, '0, '0);
    // commit goes out first, the update waits for the next frame
    produce();
    produce();
    // partner offers raw only, we support lz4 and zstd: no shared algorithm
    consume(HdrCommit, local_epoch, 16'h0001, 3'b001, HdrNone, '0, '0);
    produce();
    // sender-half commit naming a handle we never committed is ignored, one naming the committed handle is taken
    consume(HdrNone, '0, '0, '0, HdrCommit, '0, 16'h1234);
    consume(HdrNone, '0, '0, '0, HdrCommit, '0, '1);
    announce('0);
    set_algos(3'b111);
    set_algos(3'b000);
    produce();
    // commit with a stale epoch is dropped
    consume(HdrCommit, local_epoch + 1, '0, 3'b111, HdrUpdate, 64'h8000_0000_0000_0000, '0);
    produce();
    produce();
    consume(HdrCommit, local_epoch, '0, 3'b010, HdrNone, '0, '0);
    produce();
    base = sent;

    // random part: mostly well-formed rounds, some fully random items
    for (mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
          // the sink holds off while the sender keeps offering
          hold_req  = 1'b1;
        end
        1: begin
          gap_pct   = 46;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 46;
        end
        default: begin
          gap_pct   = 16;
          stall_pct = 16;
        end
      endcase
      while (sent < base + (mix + 1) * RandomPerMix) begin
        if (chance(75)) begin
          run_exchange();
        end else begin
          noise.action  = act_e'($urandom_range(3));
          noise.dict    = handle_t'($urandom);
          noise.algos   = AlgoMaskW'($urandom_range(7));
          noise.s_hdr   = HdrW'($urandom_range(3));
          noise.s_epoch = {$urandom, $urandom};
          noise.s_dict  = chance(50) ? last_dict : handle_t'($urandom);
          noise.r_hdr   = HdrW'($urandom_range(3));
          noise.r_epoch = chance(50) ? local_epoch : {$urandom, $urandom};
          noise.r_dict  = handle_t'($urandom);
          noise.r_algos = AlgoMaskW'($urandom_range(7));
          offer_event(noise);
        end
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    // drain: every expected item in, then a short quiet tail for strays
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    $display("run covered %0d events: %0d announce, %0d algo set, %0d consume, %0d produce",
             sent, act_seen[int'(ActAnnounce)], act_seen[int'(ActSetAlgos)],
             act_seen[int'(ActConsume)], act_seen[int'(ActProduce)]);
    $display("%0d frames checked, four idle mixes and a %0d-cycle sink hold-off, %0d mismatches",
             frames, HoldCycles, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/dah_pkg.sv
sv/dah_if.sv
sv/dah_step.sv
sv/dict_algo_handshake_unit.sv
verif/dah_checker.sv
verif/tb_top.sv
